### hdl/asprd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asprd_pkg
// shared constants, types and helpers of the round detector
// ----------------------------------------------------------------------------
package asprd_pkg;

  localparam int MAX_BINS      = 256;
  localparam int COUNT_BITS    = 16;
  localparam int ADDR_BITS     = $clog2(MAX_BINS);
  localparam int BIN_CNT_BITS  = $clog2(MAX_BINS + 1);
  localparam int IDX_BITS      = 8;
  localparam int CFG_BITS      = 9;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int RESET_BINS    = 256;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // register index, taken from paddr bit 2
  localparam logic REG_BINS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOK_WR,
    ST_WALK_RD,
    ST_WALK_WR
  } state_t;

  typedef enum logic {
    CNT_INC_SAT,
    CNT_DEC_FLOOR
  } cnt_op_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] result;
    logic                  was_zero;
    logic                  was_one;
  } cnt_res_t;

  typedef struct packed {
    logic                  clear;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
  } mem_req_t;

  // zero is taken as one, values above the bin count are clipped
  function automatic logic [BIN_CNT_BITS-1:0] limit_bins(input logic [CFG_BITS-1:0] v);
    logic [BIN_CNT_BITS-1:0] r;
    if (v == '0) begin
      r = BIN_CNT_BITS'(1);
    end else if (int'(v) > MAX_BINS) begin
      r = BIN_CNT_BITS'(MAX_BINS);
    end else begin
      r = BIN_CNT_BITS'(v);
    end
    return r;
  endfunction

endpackage

### hdl/asprd_count_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asprd_count_mem
// token count memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module asprd_count_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  asprd_pkg::mem_req_t             req,
  output logic [asprd_pkg::COUNT_BITS-1:0] rd_data
);

  logic [asprd_pkg::COUNT_BITS-1:0] mem [asprd_pkg::MAX_BINS];
  logic [asprd_pkg::MAX_BINS-1:0]   valid_r;
  logic [asprd_pkg::COUNT_BITS-1:0] rd_data_r;

  // valid bits make a cleared entry read as zero
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/asprd_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asprd_alu
// shared count unit: saturating increment or floored decrement
// ----------------------------------------------------------------------------
module asprd_alu (
  input  asprd_pkg::cnt_op_t               op,
  input  logic [asprd_pkg::COUNT_BITS-1:0] count,
  output asprd_pkg::cnt_res_t              res
);

  always_comb begin
    res.was_zero = (count == '0);
    res.was_one  = (count == asprd_pkg::COUNT_BITS'(1));
    case (op)
      asprd_pkg::CNT_INC_SAT: begin
        res.result = (count == asprd_pkg::COUNT_MAX) ? count
                                                     : count + asprd_pkg::COUNT_BITS'(1);
      end
      asprd_pkg::CNT_DEC_FLOOR: begin
        res.result = (count == '0) ? count : count - asprd_pkg::COUNT_BITS'(1);
      end
      default: begin
        res.result = count;
      end
    endcase
  end

endmodule

### hdl/all_sources_present_round_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_sources_present_round_detector_unit
// n-way join barrier: per-bin token counts, round done when no bin is empty
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on out_strobe for exactly one cycle and cannot be held off. A token with an
// index at or above bins_in_use is flagged in the cycle after it is taken and
// busy never rises, so such requests can follow every cycle. A valid token
// that completes no round keeps busy high through ST_TOK_WR (count read, then
// update and write). A token that completes a round adds a walk over the count
// memory that takes one token from each bin, reading the next bin while the
// last is written back through the single read and single write port of the
// count memory. The result strobe rises in the same cycle that busy falls.
// Writing bins_in_use clears all counts at once through per-bin valid bits.
// ----------------------------------------------------------------------------
module all_sources_present_round_detector_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // token request
  input  logic                                  start,
  output logic                                  busy,
  input  logic [asprd_pkg::IDX_BITS-1:0]        in_bin_index,
  // result
  output logic                                  out_strobe,
  output logic                                  out_round_done,
  output logic                                  out_index_invalid,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [asprd_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [asprd_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [asprd_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                  pready
);

  asprd_pkg::state_t                    state_r, state_nxt;
  logic [asprd_pkg::ADDR_BITS-1:0]      idx_r, idx_nxt;
  logic [asprd_pkg::ADDR_BITS-1:0]      walk_idx_r, walk_idx_nxt;
  logic [asprd_pkg::BIN_CNT_BITS-1:0]   empty_r, empty_nxt;
  logic [asprd_pkg::BIN_CNT_BITS-1:0]   bins_r, bins_nxt;
  logic                                 out_strobe_r, out_strobe_nxt;
  logic                                 out_round_done_r, out_round_done_nxt;
  logic                                 out_index_invalid_r, out_index_invalid_nxt;

  asprd_pkg::mem_req_t                  mem_req;
  logic [asprd_pkg::COUNT_BITS-1:0]     rd_data;
  asprd_pkg::cnt_op_t                   alu_op;
  asprd_pkg::cnt_res_t                  alu_res;

  logic                                 cfg_wr;
  logic                                 accept;
  logic                                 idx_bad;
  logic                                 walk_last;
  logic [asprd_pkg::BIN_CNT_BITS-1:0]   empty_upd;
  logic [asprd_pkg::BIN_CNT_BITS-1:0]   cfg_bins;

  // ---------------------------------------------------------------- config
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == asprd_pkg::REG_BINS_IN_USE);
  assign cfg_bins = asprd_pkg::limit_bins(pwdata[asprd_pkg::CFG_BITS-1:0]);
  assign prdata   = (paddr[2] == asprd_pkg::REG_BINS_IN_USE)
                    ? asprd_pkg::APB_DATA_BITS'(bins_r) : '0;

  // ---------------------------------------------------------------- datapath
  asprd_count_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  asprd_alu u_alu (
    .op    (alu_op),
    .count (rd_data),
    .res   (alu_res)
  );

  assign busy      = (state_r != asprd_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign idx_bad   = int'(in_bin_index) >= int'(bins_r);
  assign walk_last = (asprd_pkg::BIN_CNT_BITS'(walk_idx_r) == bins_r - 1'b1);
  // first token into an empty bin lowers the empty count
  assign empty_upd = (alu_res.was_zero && (empty_r != '0)) ? empty_r - 1'b1 : empty_r;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt             = state_r;
    idx_nxt               = idx_r;
    walk_idx_nxt          = walk_idx_r;
    empty_nxt             = empty_r;
    bins_nxt              = bins_r;
    out_strobe_nxt        = 1'b0;
    out_round_done_nxt    = 1'b0;
    out_index_invalid_nxt = 1'b0;
    alu_op                = asprd_pkg::CNT_DEC_FLOOR;
    mem_req.clear         = 1'b0;
    mem_req.rd_en         = 1'b0;
    mem_req.rd_addr       = walk_idx_r;
    mem_req.wr_en         = 1'b0;
    mem_req.wr_addr       = walk_idx_r;
    mem_req.wr_data       = alu_res.result;

    case (state_r)
      asprd_pkg::ST_IDLE: begin
        if (accept) begin
          if (idx_bad) begin
            // ignored token, flagged right away
            out_strobe_nxt        = 1'b1;
            out_index_invalid_nxt = 1'b1;
          end else begin
            idx_nxt         = asprd_pkg::ADDR_BITS'(in_bin_index);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = asprd_pkg::ADDR_BITS'(in_bin_index);
            state_nxt       = asprd_pkg::ST_TOK_WR;
          end
        end
      end
      asprd_pkg::ST_TOK_WR: begin
        alu_op          = asprd_pkg::CNT_INC_SAT;
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r;
        empty_nxt       = empty_upd;
        if (empty_upd == '0) begin
          // all bins hold a token: start the take-one walk
          walk_idx_nxt = '0;
          state_nxt    = asprd_pkg::ST_WALK_RD;
        end else begin
          out_strobe_nxt = 1'b1;
          state_nxt      = asprd_pkg::ST_IDLE;
        end
      end
      asprd_pkg::ST_WALK_RD: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = asprd_pkg::ST_WALK_WR;
      end
      asprd_pkg::ST_WALK_WR: begin
        mem_req.wr_en = 1'b1;
        if (alu_res.was_one) begin
          empty_nxt = empty_r + 1'b1;
        end
        if (walk_last) begin
          out_strobe_nxt     = 1'b1;
          out_round_done_nxt = 1'b1;
          state_nxt          = asprd_pkg::ST_IDLE;
        end else begin
          // read the next bin while the current one is written back
          walk_idx_nxt    = walk_idx_r + 1'b1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = walk_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = asprd_pkg::ST_IDLE;
      end
    endcase

    // register write clears counts and reloads the empty count
    if (cfg_wr) begin
      bins_nxt      = cfg_bins;
      empty_nxt     = cfg_bins;
      mem_req.clear = 1'b1;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= asprd_pkg::ST_IDLE;
      bins_r              <= asprd_pkg::limit_bins(asprd_pkg::CFG_BITS'(asprd_pkg::RESET_BINS));
      empty_r             <= asprd_pkg::limit_bins(asprd_pkg::CFG_BITS'(asprd_pkg::RESET_BINS));
      out_strobe_r        <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      bins_r              <= bins_nxt;
      empty_r             <= empty_nxt;
      out_strobe_r        <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r               <= idx_nxt;
    walk_idx_r          <= walk_idx_nxt;
    out_round_done_r    <= out_round_done_nxt;
    out_index_invalid_r <= out_index_invalid_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_round_done    = out_round_done_r;
  assign out_index_invalid = out_index_invalid_r;

endmodule

### hdl/asprd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asprd_checker
// port-level checks of the round detector, bound to the top level
// ----------------------------------------------------------------------------
module asprd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_round_done,
  input logic out_index_invalid
);

  // a result never flags both a round and an invalid index
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_round_done && out_index_invalid))
    else $error("round_done and index_invalid together");

  // every request either starts work or is answered next cycle
  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request neither busy nor answered");

  // end of work always delivers a result
  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("busy fell without a result");

  // no result while a request is in progress
  a_quiet_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result during busy");

  // a round only comes out of a walk
  a_round_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_round_done) |-> $past(busy))
    else $error("round without a walk");

endmodule

bind all_sources_present_round_detector_unit asprd_checker u_asprd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_round_done    (out_round_done),
  .out_index_invalid (out_index_invalid)
);

### test/all_sources_present_round_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_sources_present_round_detector_unit_tb
// self-checking bench for the n-way join round detector
// ----------------------------------------------------------------------------
// Token requests go in through the start/busy handshake, and bins_in_use is
// written over the APB port. A join predictor in the bench keeps its own bin
// counts. Each accepted request queues its expected round_done and
// index_invalid flags, and every out_strobe pulse is checked against the
// oldest entry. Directed tests cover reset state, the single bin case, the
// register limits, writes to the unmapped address, clearing on write and
// rounds in a row. Random phases then switch bins_in_use and send shuffled
// full rounds, partial rounds and noise.
// ----------------------------------------------------------------------------
module all_sources_present_round_detector_unit_tb;

  localparam int NUM_BINS      = asprd_pkg::MAX_BINS;
  localparam int CNT_W         = asprd_pkg::COUNT_BITS;
  localparam int IDX_W         = asprd_pkg::IDX_BITS;
  localparam int CFG_W         = asprd_pkg::CFG_BITS;
  localparam int ADDR_W        = asprd_pkg::APB_ADDR_BITS;
  localparam int DATA_W        = asprd_pkg::APB_DATA_BITS;
  localparam int RANDOM_TOKENS = 1150;
  localparam int MAX_GAP       = 18;
  localparam int MAX_REPORTS   = 100;
  // the tail leaves room for a full walk over every bin
  localparam int TAIL_CYCLES   = NUM_BINS + 40;
  // sized for the longest gap plus a full walk on every request
  localparam int CYCLE_LIMIT   = 3_000_000;

  // bins_in_use sits at byte address 0, the other word of the port is unmapped
  localparam logic [ADDR_W-1:0] ADDR_BINS     = {asprd_pkg::REG_BINS_IN_USE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = {~asprd_pkg::REG_BINS_IN_USE, 2'b00};

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic             round_done;
    logic             index_invalid;
  } join_outcome_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [IDX_W-1:0]  in_bin_index;
  logic              out_strobe;
  logic              out_round_done;
  logic              out_index_invalid;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state: its own copy of the counts and of the register
  logic [CNT_W-1:0] bin_tokens [NUM_BINS];
  int               vacant_bins;
  int               active_bins;

  // flags of accepted requests whose result strobe is still to come
  join_outcome_t    expected_outcomes [$];

  int  cycle_count     = 0;
  int  error_count     = 0;
  int  requests_sent   = 0;
  int  valid_sent      = 0;
  int  invalid_sent    = 0;
  int  rounds_expected = 0;
  int  reg_writes      = 0;
  bit  no_idle_stretch = 1'b0;

  all_sources_present_round_detector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_bin_index      (in_bin_index),
    .out_strobe        (out_strobe),
    .out_round_done    (out_round_done),
    .out_index_invalid (out_index_invalid),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_bins();
    for (int j = 0; j < NUM_BINS; j++) begin
      bin_tokens[j] = '0;
    end
    vacant_bins = active_bins;
  endfunction

  // only the bins_in_use word is decoded, zero reads as one bin, values above 256 clip
  function automatic void apply_reg_write(input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data);
    logic [CFG_W-1:0] raw;
    raw = data[CFG_W-1:0];
    if (addr[2] == asprd_pkg::REG_BINS_IN_USE) begin
      if (raw == '0) begin
        active_bins = 1;
      end else if (int'(raw) > NUM_BINS) begin
        active_bins = NUM_BINS;
      end else begin
        active_bins = int'(raw);
      end
      clear_bins();
    end
  endfunction

  // one token: count it, and when no bin is left empty take one from each
  function automatic join_outcome_t apply_token(input logic [IDX_W-1:0] idx);
    join_outcome_t r;
    r.bin_index     = idx;
    r.round_done    = 1'b0;
    r.index_invalid = 1'b0;
    if (int'(idx) >= active_bins) begin
      r.index_invalid = 1'b1;
    end else begin
      if (bin_tokens[idx] == '0) begin
        if (vacant_bins > 0) begin
          vacant_bins--;
        end
        bin_tokens[idx] = CNT_W'(1);
      end else if (bin_tokens[idx] != '1) begin
        // a full count just drops the token
        bin_tokens[idx] = bin_tokens[idx] + 1'b1;
      end
      if (vacant_bins == 0) begin
        for (int j = 0; j < active_bins; j++) begin
          if (bin_tokens[j] == CNT_W'(1)) begin
            vacant_bins++;
          end
          if (bin_tokens[j] != '0) begin
            bin_tokens[j] = bin_tokens[j] - 1'b1;
          end
        end
        r.round_done = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // results cannot be held off, so every strobe is taken at the edge ending it
  always @(posedge clk) begin : result_check
    join_outcome_t want;
    if (rst_n && out_strobe) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        if (out_round_done !== want.round_done) begin
          report_mismatch($sformatf("bin %0d: round_done %b, expected %b",
                                    want.bin_index, out_round_done, want.round_done));
        end
        if (out_index_invalid !== want.index_invalid) begin
          report_mismatch($sformatf("bin %0d: index_invalid %b, expected %b",
                                    want.bin_index, out_index_invalid,
                                    want.index_invalid));
        end
      end
    end
  end

  // hard stop in case the handshake or the result strobe hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_outcomes.size());
      $display("all_sources_present_round_detector_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // one token request; start stays high afterwards so the next can follow
  // back to back, a gap or a drain lowers it
  task automatic push_token(input logic [IDX_W-1:0] idx, input bit paced);
    int            gap;
    join_outcome_t want;
    gap = 0;
    if (paced) begin
      // flip between stretches with and without sender gaps
      if ($urandom_range(0, 23) == 0) begin
        no_idle_stretch = ~no_idle_stretch;
      end
      if (!no_idle_stretch) begin
        gap = $urandom_range(0, MAX_GAP);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_bin_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = apply_token(idx);
    expected_outcomes.insert(expected_outcomes.size(), want);
    requests_sent++;
    if (want.index_invalid) begin
      invalid_sent++;
    end else begin
      valid_sent++;
    end
    if (want.round_done) begin
      rounds_expected++;
    end
  endtask

  // hold off new requests until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0 || busy) @(posedge clk);
  endtask

  // setup then access phase, only with the block idle
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg_write(addr, data);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // reset leaves all 256 bins in use and empty: the extreme indices are valid
  task automatic test_reset_state();
    push_token(IDX_W'(0), 1'b1);
    push_token(IDX_W'(255), 1'b1);
    push_token(IDX_W'(128), 1'b1);
  endtask

  // one bin: every valid token is a round, invalid ones come every cycle
  task automatic test_single_bin();
    write_reg(ADDR_BINS, DATA_W'(1));
    push_token(IDX_W'(0), 1'b0);
    push_token(IDX_W'(0), 1'b0);
    push_token(IDX_W'(1), 1'b0);
    push_token(IDX_W'(255), 1'b0);
    push_token(IDX_W'(0), 1'b0);
  endtask

  // zero reads as one bin, anything above 256 clips to 256
  task automatic test_register_limits();
    write_reg(ADDR_BINS, DATA_W'(0));
    push_token(IDX_W'(0), 1'b1);
    push_token(IDX_W'(1), 1'b1);
    write_reg(ADDR_BINS, 32'hFFFF_FFFF);
    push_token(IDX_W'(255), 1'b1);
    write_reg(ADDR_BINS, DATA_W'(257));
    push_token(IDX_W'(255), 1'b1);
    push_token(IDX_W'(0), 1'b1);
    write_reg(ADDR_BINS, DATA_W'(256));
    push_token(IDX_W'(255), 1'b1);
  endtask

  // a write to the unmapped word must neither change bins_in_use nor clear
  task automatic test_unmapped_register();
    write_reg(ADDR_BINS, DATA_W'(3));
    push_token(IDX_W'(0), 1'b1);
    write_reg(ADDR_UNMAPPED, DATA_W'(1));
    push_token(IDX_W'(1), 1'b1);
    push_token(IDX_W'(2), 1'b1);
    push_token(IDX_W'(3), 1'b1);
  endtask

  // rewriting the same value still drops the tokens already held
  task automatic test_config_clears();
    write_reg(ADDR_BINS, DATA_W'(2));
    push_token(IDX_W'(0), 1'b1);
    write_reg(ADDR_BINS, DATA_W'(2));
    push_token(IDX_W'(1), 1'b1);
    push_token(IDX_W'(0), 1'b1);
  endtask

  // surplus tokens in bin 0 let the first three tokens to bin 1 finish a round each
  task automatic test_rounds_in_a_row();
    write_reg(ADDR_BINS, DATA_W'(2));
    repeat (3) push_token(IDX_W'(0), 1'b0);
    repeat (4) push_token(IDX_W'(1), 1'b1);
  endtask

  // phases of random bins_in_use with shuffled rounds, partial rounds, noise
  task automatic test_random_phases();
    logic [IDX_W-1:0]  order [NUM_BINS];
    logic [IDX_W-1:0]  swap;
    logic [CFG_W-1:0]  raw;
    logic [DATA_W-1:0] wdata;
    int                first_sent;
    int                sequences;
    int                kind;
    int                len;
    int                k;
    first_sent = requests_sent;
    while (requests_sent - first_sent < RANDOM_TOKENS) begin
      case ($urandom_range(0, 11))
        0:       raw = CFG_W'(1);
        1:       raw = CFG_W'(0);
        2:       raw = CFG_W'(256);
        3:       raw = '1;
        4:       raw = CFG_W'(255);
        5:       raw = CFG_W'($urandom_range(17, 255));
        default: raw = CFG_W'($urandom_range(2, 16));
      endcase
      // upper bits of the data word carry junk, only the low field counts
      wdata = $urandom();
      wdata[CFG_W-1:0] = raw;
      write_reg(ADDR_BINS, wdata);
      // full rounds over many bins are long, keep those phases short
      sequences = (active_bins > 32) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      repeat (sequences) begin
        for (int i = 0; i < active_bins; i++) begin
          order[i] = IDX_W'(i);
        end
        for (int i = active_bins - 1; i > 0; i--) begin
          k        = $urandom_range(0, i);
          swap     = order[i];
          order[i] = order[k];
          order[k] = swap;
        end
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // one token to every bin in shuffled order, with stray duplicates
          for (int i = 0; i < active_bins; i++) begin
            push_token(order[i], 1'b1);
            if ($urandom_range(0, 7) == 0) begin
              push_token(IDX_W'($urandom_range(0, active_bins - 1)), 1'b1);
            end
          end
        end else if (kind < 8) begin
          // broken round: only part of the bins get a token
          len = $urandom_range(0, active_bins - 1);
          for (int i = 0; i < len; i++) begin
            push_token(order[i], 1'b1);
          end
        end else begin
          // noise over the whole index range, mostly invalid for small counts
          repeat ($urandom_range(3, 16)) push_token(IDX_W'($urandom_range(0, 255)), 1'b1);
        end
        // sender pause until all outstanding results are back
        if ($urandom_range(0, 3) == 0) begin
          drain_results();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_bin_index <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    active_bins   = asprd_pkg::RESET_BINS;
    clear_bins();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_single_bin();
    test_register_limits();
    test_unmapped_register();
    test_config_clears();
    test_rounds_in_a_row();
    test_random_phases();

    // let the last walk finish and catch any stray strobe
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
    end

    $display("covered %0d token requests (%0d valid, %0d out of range) with %0d rounds",
             requests_sent, valid_sent, invalid_sent, rounds_expected);
    $display("across %0d register writes, bins_in_use from 1 to 256, %0d mismatches",
             reg_writes, error_count);
    if (error_count == 0) begin
      $display("all_sources_present_round_detector_unit verification clean");
    end else begin
      $display("all_sources_present_round_detector_unit verification failed");
    end
    $finish;
  end

endmodule
